>>> sv/integer_to_ascii_formatter_core_macros.svh
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: assertion macros
// Shorthand for clocked implication checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication
`define ITOA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ITOA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/itoa_fmt_pkg.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared constants, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package itoa_fmt_pkg;

  // Operand and digit store geometry
  localparam int VAL_W         = 64;
  localparam int NDIG          = 20;
  localparam int DIG_W         = 4 * NDIG;
  localparam int LEN_W         = $clog2(NDIG + 1);
  localparam int CNT_W         = $clog2(VAL_W);
  localparam int DEF_MAX_WIDTH = 32;
  localparam int MW_W          = 6;
  localparam int CLAMP_W       = 7;

  // Conversion codes
  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_PTR  = 2'd3;

  // Register indexes (byte address bit 2)
  localparam logic REG_MIN_WIDTH = 1'b0;
  localparam logic REG_PAD_ZERO  = 1'b1;

  // ASCII characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Character source select
  localparam logic [2:0] SEL_MINUS = 3'd0;
  localparam logic [2:0] SEL_ZERO  = 3'd1;
  localparam logic [2:0] SEL_X     = 3'd2;
  localparam logic [2:0] SEL_PAD   = 3'd3;
  localparam logic [2:0] SEL_DIGIT = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       dabble;
    logic       shift;
    logic       load_pad;
    logic       pad_dec;
    logic       emit;
    logic [2:0] sel;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic dec;
    logic dab_last;
    logic top_zero;
    logic len_one;
    logic pad_zero;
    logic neg;
    logic ptr;
  } dp_stat_t;

endpackage

>>> sv/itoa_fmt_dp.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter datapath
// Operand conditioning, shift-add-3 BCD conversion, leading zero strip,
// pad count and the registered character output.
// ----------------------------------------------------------------------------
module itoa_fmt_dp import itoa_fmt_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       in_opcode,
  input  logic             in_is_long,
  input  logic [VAL_W-1:0] in_value,
  input  logic [MW_W-1:0]  min_width,
  input  logic             pad_zero,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic             out_valid,
  output logic [7:0]       out_ch,
  output logic             out_last
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [DIG_W-1:0] dig_r;
  logic [VAL_W-1:0] bin_r;
  logic [LEN_W-1:0] len_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WW-1:0]    pad_r;
  logic             neg_r;
  logic             ptr_r;
  logic             dec_r;
  logic             out_valid_r;
  logic [7:0]       out_ch_r;
  logic             out_last_r;

  logic [VAL_W-1:0] ext;
  logic [VAL_W-1:0] mag;
  logic             neg;
  logic [DIG_W-1:0] adj;
  logic [3:0]       top;
  logic [7:0]       dchar;
  logic [WW-1:0]    wdt;
  logic [WW-1:0]    need;
  logic [WW-1:0]    pad_calc;

  // Condition operand: width select, sign extension, magnitude
  always_comb begin
    ext = in_value;
    if (in_opcode != OP_PTR && !in_is_long) begin
      if (in_opcode == OP_SDEC) begin
        ext = {{(VAL_W-32){in_value[31]}}, in_value[31:0]};
      end else begin
        ext = {{(VAL_W-32){1'b0}}, in_value[31:0]};
      end
    end
    neg = (in_opcode == OP_SDEC) && ext[VAL_W-1];
    mag = neg ? (~ext + VAL_W'(1)) : ext;
  end

  // Add 3 to every BCD digit of five or more
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3 : dig_r[4*i +: 4];
    end
  end

  // Character of the leading digit
  assign top   = dig_r[DIG_W-1 -: 4];
  assign dchar = (top > 4'd9) ? (CH_A + {4'b0, top} - 8'd10) : (CH_ZERO + {4'b0, top});

  // Clamp width and work out the pad count
  always_comb begin
    wdt = ({1'b0, min_width} > CLAMP_W'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(min_width);
    need = WW'(len_r) + WW'(neg_r);
    pad_calc = (wdt > need) ? (wdt - need) : '0;
  end

  // Digit store, counters and flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= neg;
      ptr_r <= (in_opcode == OP_PTR);
      dec_r <= (in_opcode == OP_SDEC) || (in_opcode == OP_UDEC);
      bin_r <= mag;
      dig_r <= ((in_opcode == OP_SDEC) || (in_opcode == OP_UDEC)) ? '0 : DIG_W'(mag);
      len_r <= LEN_W'(NDIG);
      cnt_r <= '0;
    end else if (cmd.dabble) begin
      dig_r <= {adj[DIG_W-2:0], bin_r[VAL_W-1]};
      bin_r <= {bin_r[VAL_W-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.shift) begin
      dig_r <= {dig_r[DIG_W-5:0], 4'b0};
      len_r <= len_r - LEN_W'(1);
    end
    if (cmd.load_pad) begin
      pad_r <= pad_calc;
    end else if (cmd.pad_dec) begin
      pad_r <= pad_r - WW'(1);
    end
  end

  // Output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  // Output character and last mark
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last_r <= (cmd.sel == SEL_DIGIT) && (len_r == LEN_W'(1));
      unique case (cmd.sel)
        SEL_MINUS: out_ch_r <= CH_MINUS;
        SEL_ZERO:  out_ch_r <= CH_ZERO;
        SEL_X:     out_ch_r <= CH_X;
        SEL_PAD:   out_ch_r <= pad_zero ? CH_ZERO : CH_SPACE;
        SEL_DIGIT: out_ch_r <= dchar;
        default:   out_ch_r <= dchar;
      endcase
    end
  end

  assign stat.dec      = dec_r;
  assign stat.dab_last = (cnt_r == CNT_W'(VAL_W - 1));
  assign stat.top_zero = (top == 4'd0);
  assign stat.len_one  = (len_r == LEN_W'(1));
  assign stat.pad_zero = (pad_r == '0);
  assign stat.neg      = neg_r;
  assign stat.ptr      = ptr_r;

  assign out_valid = out_valid_r;
  assign out_ch    = out_ch_r;
  assign out_last  = out_last_r;

endmodule

>>> sv/itoa_fmt_ctrl.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter controller
// Sequences load, conversion, zero strip, prefix, padding and digits.
// ----------------------------------------------------------------------------
module itoa_fmt_ctrl import itoa_fmt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DAB   = 4'd1;
  localparam logic [3:0] S_NORM  = 4'd2;
  localparam logic [3:0] S_PADC  = 4'd3;
  localparam logic [3:0] S_MINUS = 4'd4;
  localparam logic [3:0] S_ZERO  = 4'd5;
  localparam logic [3:0] S_X     = 4'd6;
  localparam logic [3:0] S_PAD   = 4'd7;
  localparam logic [3:0] S_DIGIT = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_DIGIT;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DAB;
        end
      end
      S_DAB: begin
        if (!stat.dec) begin
          state_nxt = S_NORM;
        end else begin
          cmd.dabble = 1'b1;
          if (stat.dab_last) begin
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (stat.top_zero && !stat.len_one) begin
          cmd.shift = 1'b1;
        end else begin
          state_nxt = S_PADC;
        end
      end
      S_PADC: begin
        cmd.load_pad = 1'b1;
        priority if (stat.neg) begin
          state_nxt = S_MINUS;
        end else if (stat.ptr) begin
          state_nxt = S_ZERO;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_MINUS: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_MINUS;
        state_nxt = S_PAD;
      end
      S_ZERO: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_ZERO;
        state_nxt = S_X;
      end
      S_X: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_X;
        state_nxt = S_PAD;
      end
      S_PAD: begin
        cmd.emit = 1'b1;
        if (!stat.pad_zero) begin
          cmd.sel     = SEL_PAD;
          cmd.pad_dec = 1'b1;
        end else begin
          cmd.shift = 1'b1;
          state_nxt = stat.len_one ? S_IDLE : S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.emit  = 1'b1;
        cmd.shift = 1'b1;
        if (stat.len_one) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> sv/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter core
// Formats one 32- or 64-bit integer as signed/unsigned decimal, hex or
// pointer hex, emitted as a string of ASCII characters.
//
// Requests are issued with start while busy is low; in_opcode, in_is_long
// and in_value are sampled on that edge. Characters come out most
// significant first on out_ch with out_valid high for one cycle each, and
// out_last marks the final character. The receiver cannot stall: every
// character is taken in the cycle it is shown.
// Each request runs from the accepting edge: shift-add-3 conversion for
// decimal (skipped for hex), stripping of S leading zeros (S is 0 to 19, at
// least 4 for hex), the pad count, then the N characters (1 to 34 with the
// default MAX_WIDTH). busy drops with the last character, so a new request
// may start while that character is shown. Reset clears the sequencer,
// the output strobe, min_width and pad_zero. min_width and pad_zero are
// written over the APB port; the user must do so only while idle, as the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_core_macros.svh"

module integer_to_ascii_formatter_core import itoa_fmt_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_opcode,
  input  logic             in_is_long,
  input  logic [VAL_W-1:0] in_value,
  // character channel
  output logic             out_valid,
  output logic [7:0]       out_ch,
  output logic             out_last,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [MW_W-1:0] min_width_r;
  logic            pad_zero_r;
  logic            cfg_wr;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_width_r <= '0;
      pad_zero_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MIN_WIDTH: min_width_r <= pwdata[MW_W-1:0];
        REG_PAD_ZERO:  pad_zero_r  <= pwdata[0];
        default:       pad_zero_r  <= pad_zero_r;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      REG_MIN_WIDTH: prdata = {{(32-MW_W){1'b0}}, min_width_r};
      REG_PAD_ZERO:  prdata = {31'b0, pad_zero_r};
      default:       prdata = '0;
    endcase
  end

  itoa_fmt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  itoa_fmt_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_opcode  (in_opcode),
    .in_is_long (in_is_long),
    .in_value   (in_value),
    .min_width  (min_width_r),
    .pad_zero   (pad_zero_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ch     (out_ch),
    .out_last   (out_last)
  );

  // A taken request keeps the block busy
  `ITOA_ASSERT_NXT(a_start_busy, start && !busy, busy, "request taken but block not busy")
  // More characters follow only while busy
  `ITOA_ASSERT_IMP(a_mid_busy, out_valid && !out_last, busy, "character mid-number while idle")
  // The final character frees the block
  `ITOA_ASSERT_IMP(a_last_idle, out_valid && out_last, !busy, "still busy after last character")

endmodule

>>> tb/integer_to_ascii_formatter_checker.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: character stream checker
// Watches the request, character and APB channels. It keeps its own copy of
// min_width and pad_zero, formats each accepted request into the characters
// it should produce, and compares every emitted character in order.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_checker import itoa_fmt_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       in_opcode,
  input  logic             in_is_long,
  input  logic [VAL_W-1:0] in_value,
  input  logic             out_valid,
  input  logic [7:0]       out_ch,
  input  logic             out_last,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_exp_t;

  char_exp_t         char_q[$];
  char_exp_t         head;
  logic [MW_W-1:0]   width_reg;
  logic              pad_reg;
  int                errs;

  initial begin
    errs        = 0;
    mismatches  = 0;
    outstanding = 0;
  end

  // Format one number into the expected character stream
  function automatic void format_number(input logic [1:0] op, input logic lng,
                                        input logic [VAL_W-1:0] raw);
    logic [VAL_W-1:0] mag;
    logic [VAL_W-1:0] radix;
    logic [VAL_W-1:0] digit;
    logic             neg;
    logic [7:0]       digits[$];
    logic [7:0]       line[$];
    int               field;
    int               fill;
    mag   = raw;
    neg   = 1'b0;
    radix = (op == OP_HEX || op == OP_PTR) ? 64'd16 : 64'd10;
    case (op)
      OP_SDEC: begin
        if (!lng)
          mag = {{32{raw[31]}}, raw[31:0]};
        if (mag[VAL_W-1]) begin
          neg = 1'b1;
          mag = -mag;
        end
      end
      OP_UDEC, OP_HEX: begin
        if (!lng)
          mag = {32'd0, raw[31:0]};
      end
      default: ;
    endcase

    // Collect digits, least significant first, into the front of the list
    if (mag == 0)
      digits.push_front(CH_ZERO);
    while (mag != 0) begin
      digit = mag % radix;
      digits.push_front(digit > 9 ? CH_A + digit[7:0] - 8'd10 : CH_ZERO + digit[7:0]);
      mag = mag / radix;
    end

    // Prefix, then padding against the clamped width, then the digits
    field = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    if (neg) begin
      line.push_back(CH_MINUS);
      field--;
    end else if (op == OP_PTR) begin
      line.push_back(CH_ZERO);
      line.push_back(CH_X);
    end
    fill = field - digits.size();
    for (int i = 0; i < fill; i++)
      line.push_back(pad_reg ? CH_ZERO : CH_SPACE);
    foreach (digits[i])
      line.push_back(digits[i]);

    foreach (line[i])
      char_q.push_back('{ch: line[i], last: (i == line.size() - 1)});
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = '0;
      pad_reg   = 1'b0;
      char_q.delete();
    end else begin
      // Compare each emitted character with the oldest expectation
      if (out_valid) begin
        if (char_q.size() == 0) begin
          $display("%0t: unexpected character ch=%h last=%b", $realtime, out_ch, out_last);
          errs++;
        end else begin
          head = char_q.pop_front();
          if (head.ch !== out_ch) begin
            $display("%0t: ch mismatch: expected %h, got %h", $realtime, head.ch, out_ch);
            errs++;
          end
          if (head.last !== out_last) begin
            $display("%0t: last mismatch: expected %b, got %b", $realtime,
                     head.last, out_last);
            errs++;
          end
        end
      end
      // Predict the characters of each accepted request
      if (start && !busy)
        format_number(in_opcode, in_is_long, in_value);
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MIN_WIDTH)
          width_reg = pwdata[MW_W-1:0];
        else
          pad_reg = pwdata[0];
      end
    end
    mismatches  <= errs;
    outstanding <= char_q.size();
  end

endmodule

>>> tb/tb_integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: testbench top
// Drives requests and APB register writes into the formatter: a directed set
// of edge values and every conversion, then random numbers over several
// width and padding settings with random sender gaps. The checker beside the
// block predicts and compares the characters; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_core;
  timeunit 1ns;
  timeprecision 1ps;
  import itoa_fmt_pkg::*;

  localparam int         RESET_CYCLES  = 9;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 120;
  localparam int         PHASES        = 7;
  localparam int         PHASE_ITEMS   = 13;
  localparam logic [2:0] ADDR_MIN_WIDTH = {REG_MIN_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_PAD_ZERO  = {REG_PAD_ZERO, 2'b00};

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_opcode;
  logic             in_is_long;
  logic [VAL_W-1:0] in_value;
  logic             out_valid;
  logic [7:0]       out_ch;
  logic             out_last;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  int               mismatches;
  int               outstanding;
  int               quiet_cycles;
  logic             gaps_on;

  integer_to_ascii_formatter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_opcode  (in_opcode),
    .in_is_long (in_is_long),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ch     (out_ch),
    .out_last   (out_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  integer_to_ascii_formatter_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_opcode   (in_opcode),
    .in_is_long  (in_is_long),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ch      (out_ch),
    .out_last    (out_last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_integer_to_ascii_formatter_core failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Issue one request, with an optional gap, and hold until it is taken
  task automatic send_number(input logic [1:0] op, input logic lng,
                             input logic [VAL_W-1:0] v);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    in_opcode  <= op;
    in_is_long <= lng;
    in_value   <= v;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every expected character has come out
  task automatic drain_chars();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Change the field format once the block is idle; upper data bits are noise
  task automatic set_format(input logic [MW_W-1:0] width, input logic padz);
    drain_chars();
    write_reg(ADDR_MIN_WIDTH, {(32-MW_W)'($urandom), width});
    write_reg(ADDR_PAD_ZERO, {31'($urandom), padz});
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = VAL_W'($urandom_range(0, 999));
      2: v = {$urandom, $urandom};
      3: v = -VAL_W'($urandom_range(1, 99999));
      4: begin
        case ($urandom_range(0, 6))
          0: v = '0;
          1: v = '1;
          2: v = 64'h8000_0000_0000_0000;
          3: v = 64'h7fff_ffff_ffff_ffff;
          4: v = {$urandom, 32'h8000_0000};
          5: v = {$urandom, 32'hffff_ffff};
          default: v = {$urandom, 32'h7fff_ffff};
        endcase
      end
      default: v = VAL_W'(1) << $urandom_range(0, VAL_W - 1);
    endcase
    return v;
  endfunction

  initial begin
    logic [MW_W-1:0] width;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_opcode  <= OP_SDEC;
    in_is_long <= 1'b0;
    in_value   <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    gaps_on    = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset format: natural length, space padding
    send_number(OP_SDEC, 1'b1, 64'd0);
    send_number(OP_SDEC, 1'b1, 64'h8000_0000_0000_0000);
    send_number(OP_SDEC, 1'b1, 64'hffff_ffff_ffff_ffff);
    send_number(OP_SDEC, 1'b1, 64'h7fff_ffff_ffff_ffff);
    send_number(OP_SDEC, 1'b0, 64'h1234_5678_8000_0000);
    send_number(OP_SDEC, 1'b0, 64'hffff_ffff_7fff_ffff);
    send_number(OP_UDEC, 1'b1, 64'hffff_ffff_ffff_ffff);
    send_number(OP_UDEC, 1'b0, 64'hdead_beef_ffff_ffff);
    send_number(OP_HEX, 1'b1, 64'hffff_ffff_ffff_ffff);
    send_number(OP_HEX, 1'b0, 64'hffff_ffff_0000_0000);
    send_number(OP_HEX, 1'b1, 64'h0123_4567_89ab_cdef);
    send_number(OP_PTR, 1'b0, 64'hfedc_ba98_7654_3210);
    send_number(OP_PTR, 1'b1, 64'd0);

    // Zero padding to 20 characters
    set_format(6'd20, 1'b1);
    send_number(OP_SDEC, 1'b1, -64'd123);
    send_number(OP_PTR, 1'b0, 64'h0000_0000_0000_00ab);
    send_number(OP_UDEC, 1'b0, 64'd5);
    send_number(OP_HEX, 1'b0, 64'h0000_0000_dead_beef);

    // Width above the clamp, space padding
    set_format(6'd63, 1'b0);
    send_number(OP_PTR, 1'b1, 64'd1);
    send_number(OP_SDEC, 1'b0, 64'h0000_0000_ffff_ffff);

    // Widest field: pointer reaches the longest character run
    set_format(6'd32, 1'b1);
    send_number(OP_PTR, 1'b1, 64'd0);
    send_number(OP_SDEC, 1'b1, 64'h8000_0000_0000_0000);

    // Width below the digit count never truncates
    set_format(6'd1, 1'b0);
    send_number(OP_UDEC, 1'b1, 64'd12345);

    // Random numbers over a run of format settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: width = 6'd0;
        1: width = 6'd32;
        2: width = 6'd63;
        3: width = MW_W'($urandom_range(1, 20));
        4: width = MW_W'($urandom_range(33, 62));
        5: width = MW_W'($urandom_range(0, 32));
        default: width = MW_W'($urandom_range(0, 63));
      endcase
      set_format(width, 1'(p[0] ^ $urandom_range(0, 1)));
      gaps_on = (p % 3 != 2) && (p != PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (gaps_on && $urandom_range(0, 19) == 0)
          drain_chars();
        send_number(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_value());
      end
    end

    // Let the last characters out, then give the verdict
    drain_chars();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_integer_to_ascii_formatter_core passed");
    end else begin
      $display("tb_integer_to_ascii_formatter_core failed");
    end
    $finish;
  end

endmodule
